@@ rtl/nlb_pkg.sv @@
package nlb_pkg;

	localparam logic [1:0] CMD_SELECT = 2'd0;
	localparam logic [1:0] CMD_ADJUST = 2'd1;
	localparam logic [1:0] CMD_HEARTBEAT = 2'd2;
	localparam logic [1:0] CMD_HEALTH = 2'd3;

	localparam logic [1:0] MODE_ROUND_ROBIN = 2'd0;
	localparam logic [1:0] MODE_LEAST = 2'd1;
	localparam logic [1:0] MODE_HASH = 2'd2;
	localparam logic [1:0] MODE_LOCAL = 2'd3;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_FAILED = 2'd3;

	localparam logic [2:0] REG_LB_MODE = 3'd0;
	localparam logic [2:0] REG_LOCAL_ID = 3'd1;
	localparam logic [2:0] REG_PEER1_ID = 3'd2;
	localparam logic [2:0] REG_PEER2_ID = 3'd3;
	localparam logic [2:0] REG_PEER3_ID = 3'd4;
	localparam logic [2:0] REG_NODE_SLOTS = 3'd5;
	localparam logic [2:0] REG_TIMEOUT = 3'd6;

	localparam logic [31:0] HB_TIMEOUT_RESET = 32'd3;
	localparam logic [2:0] NODE_SLOTS_RESET = 3'd1;
	localparam logic [2:0] HASH_LAST_BYTE = 3'd5;
	localparam logic [2:0] MOD_LAST_STEP = 3'd7;
	localparam int MOD_BITS_PER_STEP = 4;

	typedef struct packed {
		logic [1:0] command;
		logic [47:0] mac_addr;
		logic mac_present;
		logic [31:0] target_node;
		logic signed [15:0] delta;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic [31:0] selected_node;
		logic node_matched;
		logic [3:0] failed_mask;
	} rsp_t;

	typedef struct packed {
		logic [2:0] index;
		logic [31:0] value;
	} cfg_t;

endpackage

@@ rtl/nlb_req_if.sv @@
interface nlb_req_if import nlb_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/nlb_rsp_if.sv @@
interface nlb_rsp_if import nlb_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/nlb_cfg_if.sv @@
interface nlb_cfg_if import nlb_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/node_load_balancer.sv @@
// Session load balancer over a table of MAX_NODES node slots, slot zero being the local node.
// The cfg channel writes the registers (mode, node ids, slot count, heartbeat timeout);
// it is always ready and is to be used only while the block is idle.
// Each transaction on req carries one command and yields exactly one transaction on rsp.
// The block takes one request at a time: req is ready only while the sequencer is idle.
// A single slot walker visits one slot per cycle. Round robin first brings a stale rotation
// pointer below the slot count by repeated subtraction, then walks to the next active slot;
// least sessions walks every slot in use; adjust and heartbeat walk until the target node is
// found; the health check walks the peer slots. A hash select first folds in the six MAC
// bytes, then reduces the hash modulo the active node count (four bits per cycle) and walks
// to the chosen active node, or skips to the result when no node is active. Other selects skip the walk.
// The result sits in an output register, so a new request is taken while it waits; if
// rsp stalls, the following result is held back until the register is free.
// Reset clears the registers to their defaults, marks slot zero active and the other
// slots unknown, and zeroes the session counts, heartbeat times and rotation pointer.
module node_load_balancer import nlb_pkg::*; #(
	parameter int MAX_NODES = 4
) (
	input logic clk,
	input logic arst_n,
	nlb_cfg_if.sink cfg,
	nlb_req_if.sink req,
	nlb_rsp_if.source rsp
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RR_MOD = 4'd1;
	localparam logic [3:0] S_SCAN_RR = 4'd2;
	localparam logic [3:0] S_SCAN_LS = 4'd3;
	localparam logic [3:0] S_HASH = 4'd4;
	localparam logic [3:0] S_MOD = 4'd5;
	localparam logic [3:0] S_SCAN_HASH = 4'd6;
	localparam logic [3:0] S_FIND = 4'd7;
	localparam logic [3:0] S_HEALTH = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [1:0] lb_mode_q;
	logic [31:0] local_id_q;
	logic [31:0] peer1_id_q;
	logic [31:0] peer2_id_q;
	logic [31:0] peer3_id_q;
	logic [2:0] node_slots_q;
	logic [31:0] timeout_q;

	logic [1:0] status_q [MAX_NODES];
	logic [31:0] count_q [MAX_NODES];
	logic [31:0] beat_q [MAX_NODES];
	logic [IW-1:0] rotate_q;

	logic [3:0] state_q;
	req_t req_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] step_q;
	logic [31:0] hash_q;
	logic [2:0] byte_q;
	logic [CW-1:0] act_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] seen_q;
	logic found_q;
	logic [31:0] best_q;
	logic [31:0] sel_q;
	logic matched_q;
	logic [3:0] mask_q;

	logic rsp_valid_q;
	rsp_t rsp_data_q;

	logic [CW-1:0] n_used;
	logic [31:0] cur_id;
	logic [CW-1:0] act_cnt;
	logic [CW-1:0] rem_next;
	logic [CW-1:0] idx_inc;
	logic [IW-1:0] idx_wrap;
	logic [7:0] mac_byte;
	logic [31:0] hash_next;
	logic [31:0] dec_mag;
	logic [32:0] inc_sum;
	logic cur_active;
	logic out_free;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_mode_q <= MODE_ROUND_ROBIN;
			local_id_q <= '0;
			peer1_id_q <= '0;
			peer2_id_q <= '0;
			peer3_id_q <= '0;
			node_slots_q <= NODE_SLOTS_RESET;
			timeout_q <= HB_TIMEOUT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_LB_MODE: lb_mode_q <= cfg.data.value[1:0];
				REG_LOCAL_ID: local_id_q <= cfg.data.value;
				REG_PEER1_ID: peer1_id_q <= cfg.data.value;
				REG_PEER2_ID: peer2_id_q <= cfg.data.value;
				REG_PEER3_ID: peer3_id_q <= cfg.data.value;
				REG_NODE_SLOTS: node_slots_q <= cfg.data.value[2:0];
				REG_TIMEOUT: timeout_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (node_slots_q == '0) begin
			n_used = CW'(1);
		end else if (32'(node_slots_q) > MAX_NODES) begin
			n_used = CW'(MAX_NODES);
		end else begin
			n_used = CW'(node_slots_q);
		end
	end

	always_comb begin
		if (32'(idx_q) == 32'd0) begin
			cur_id = local_id_q;
		end else if (32'(idx_q) == 32'd1) begin
			cur_id = peer1_id_q;
		end else if (32'(idx_q) == 32'd2) begin
			cur_id = peer2_id_q;
		end else if (32'(idx_q) == 32'd3) begin
			cur_id = peer3_id_q;
		end else begin
			cur_id = '0;
		end
	end

	always_comb begin
		act_cnt = '0;
		for (int s = 0; s < MAX_NODES; s++) begin
			if (s < int'(n_q) && status_q[s] == ST_ACTIVE) begin
				act_cnt = act_cnt + CW'(1);
			end
		end
	end

	always_comb begin
		logic [CW-1:0] r;
		logic [CW:0] t;
		r = rem_q;
		for (int b = 0; b < MOD_BITS_PER_STEP; b++) begin
			t = {r, hash_q[31 - b]};
			if (t >= {1'b0, act_q}) begin
				t = t - {1'b0, act_q};
			end
			r = CW'(t);
		end
		rem_next = r;
	end

	assign cur_active = (status_q[idx_q] == ST_ACTIVE);
	assign idx_inc = CW'(idx_q) + CW'(1);
	assign idx_wrap = (idx_inc == n_q) ? '0 : IW'(idx_inc);
	assign mac_byte = req_q.mac_addr[8 * (32'(HASH_LAST_BYTE) - 32'(byte_q)) +: 8];
	assign hash_next = (hash_q << 5) - hash_q + 32'(mac_byte);
	assign dec_mag = 32'(17'h10000 - {1'b0, req_q.delta});
	assign inc_sum = {1'b0, count_q[idx_q]} + 33'({1'b0, req_q.delta});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rotate_q <= '0;
			for (int s = 0; s < MAX_NODES; s++) begin
				status_q[s] <= (s == 0) ? ST_ACTIVE : ST_UNKNOWN;
				count_q[s] <= '0;
				beat_q[s] <= '0;
			end
		end else begin
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						n_q <= n_used;
						matched_q <= 1'b0;
						mask_q <= '0;
						found_q <= 1'b0;
						hash_q <= '0;
						byte_q <= '0;
						sel_q <= (req.data.command == CMD_SELECT) ? local_id_q : '0;
						unique case (req.data.command) inside
							CMD_SELECT: begin
								step_q <= n_used;
								if (lb_mode_q == MODE_ROUND_ROBIN) begin
									idx_q <= rotate_q;
									state_q <= S_RR_MOD;
								end else if (lb_mode_q == MODE_LEAST) begin
									idx_q <= '0;
									state_q <= S_SCAN_LS;
								end else if (lb_mode_q == MODE_HASH && req.data.mac_present) begin
									idx_q <= '0;
									state_q <= S_HASH;
								end else begin
									idx_q <= '0;
									state_q <= S_OUT;
								end
							end
							CMD_ADJUST, CMD_HEARTBEAT: begin
								idx_q <= '0;
								step_q <= n_used;
								state_q <= S_FIND;
							end
							CMD_HEALTH: begin
								idx_q <= IW'(1);
								step_q <= n_used - CW'(1);
								state_q <= S_HEALTH;
							end
							default: begin
								idx_q <= '0;
								step_q <= n_used;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RR_MOD: begin
					if (CW'(idx_q) >= n_q) begin
						idx_q <= IW'(CW'(idx_q) - n_q);
					end else begin
						state_q <= S_SCAN_RR;
					end
				end
				S_SCAN_RR: begin
					if (step_q == '0) begin
						state_q <= S_OUT;
					end else if (cur_active) begin
						sel_q <= cur_id;
						rotate_q <= idx_wrap;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_wrap;
						step_q <= step_q - CW'(1);
					end
				end
				S_SCAN_LS: begin
					if (step_q == '0) begin
						state_q <= S_OUT;
					end else begin
						if (cur_active && (!found_q || count_q[idx_q] < best_q)) begin
							found_q <= 1'b1;
							best_q <= count_q[idx_q];
							sel_q <= cur_id;
						end
						idx_q <= IW'(idx_inc);
						step_q <= step_q - CW'(1);
					end
				end
				S_HASH: begin
					hash_q <= hash_next;
					if (byte_q == HASH_LAST_BYTE) begin
						byte_q <= '0;
						rem_q <= '0;
						act_q <= act_cnt;
						state_q <= (act_cnt == '0) ? S_OUT : S_MOD;
					end else begin
						byte_q <= byte_q + 3'd1;
					end
				end
				S_MOD: begin
					rem_q <= rem_next;
					hash_q <= hash_q << MOD_BITS_PER_STEP;
					byte_q <= byte_q + 3'd1;
					if (byte_q == MOD_LAST_STEP) begin
						seen_q <= '0;
						state_q <= S_SCAN_HASH;
					end
				end
				S_SCAN_HASH: begin
					if (step_q == '0) begin
						state_q <= S_OUT;
					end else begin
						if (cur_active) begin
							if (seen_q == rem_q) begin
								sel_q <= cur_id;
								state_q <= S_OUT;
							end
							seen_q <= seen_q + CW'(1);
						end
						idx_q <= IW'(idx_inc);
						step_q <= step_q - CW'(1);
					end
				end
				S_FIND: begin
					if (step_q == '0) begin
						state_q <= S_OUT;
					end else if (cur_id == req_q.target_node) begin
						matched_q <= 1'b1;
						state_q <= S_OUT;
						if (req_q.command == CMD_HEARTBEAT) begin
							beat_q[idx_q] <= req_q.now_seconds;
							status_q[idx_q] <= ST_ACTIVE;
						end else if (req_q.delta[15]) begin
							if (count_q[idx_q] >= dec_mag) begin
								count_q[idx_q] <= count_q[idx_q] - dec_mag;
							end
						end else begin
							count_q[idx_q] <= inc_sum[32] ? '1 : inc_sum[31:0];
						end
					end else begin
						idx_q <= IW'(idx_inc);
						step_q <= step_q - CW'(1);
					end
				end
				S_HEALTH: begin
					if (step_q == '0) begin
						state_q <= S_OUT;
					end else begin
						if (cur_active && (req_q.now_seconds - beat_q[idx_q]) > timeout_q) begin
							status_q[idx_q] <= ST_FAILED;
							mask_q <= mask_q | 4'(32'd1 << idx_q);
						end
						idx_q <= IW'(idx_inc);
						step_q <= step_q - CW'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_data_q.selected_node <= sel_q;
						rsp_data_q.node_matched <= matched_q;
						rsp_data_q.failed_mask <= mask_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an earlier one is still in progress");

	a_local_always_active: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[0] == ST_ACTIVE)
		else $error("local slot has left the active state");

	a_local_never_failed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !rsp_data_q.failed_mask[0])
		else $error("health check reported the local slot as failed");

	a_health_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.failed_mask != 4'd0
		|-> rsp_data_q.selected_node == 32'd0 && !rsp_data_q.node_matched)
		else $error("health check result carries a selection or a match");
`endif

endmodule
